// ===== hdl/kiss64_pkg.sv =====
// Shared types and constants for the 64-bit KISS random generator core.
// Used by kiss64_ctrl, kiss64_dpath and kiss64_random_generator_core.
// Depends on nothing else.
package kiss64_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned RANGE_W = 32;

   // The congruential multiplier is 2^32 + LCG_MUL_LO, so only one 32-bit factor is stored.
   localparam logic [HALF_W-1:0] LCG_MUL_LO = 32'd2612001773;
   localparam logic [WORD_W-1:0] LCG_ADD    = 64'd1234567;

   localparam int unsigned MWC_SHIFT  = 58;
   localparam int unsigned MWC_CSHIFT = 6;
   localparam int unsigned XS_A       = 13;
   localparam int unsigned XS_B       = 17;
   localparam int unsigned XS_C       = 43;

   localparam logic [WORD_W-1:0] SEED_X_MASK = 64'd1;
   localparam logic [WORD_W-1:0] SEED_C_MASK = 64'd2;
   localparam logic [WORD_W-1:0] SEED_Y_MASK = 64'd4;
   localparam logic [WORD_W-1:0] SEED_Z_MASK = 64'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic seed_load;
      logic draw_start;
      logic lcg_step;
      logic mix_step;
      logic result_load;
   } kiss64_cmd_type;

endpackage

// ===== hdl/kiss64_random_generator_core.sv =====
// Top level of the 64-bit KISS random generator core.
// Depends on kiss64_pkg, kiss64_ctrl and kiss64_dpath.
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_tvalid/req_tready  req_tdata[31:0] = range_limit
//  rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata[63:0] = value
//  csr_      in         csr_valid/csr_ready    csr_wdata[63:0] = seed
//
// An item goes through acceptance (MWC, xorshift and the two 32x32 LCG partial
// products), LCG combine, the three-way sum, then the range scaling multiply
// into the output register. One item is in work at a time, so a new item is not
// accepted until the last one has left the last step; a full output register
// that is not taken holds the item in the last step. Reset is synchronous and
// seeds the state as if zero had been written to the seed register; a seed
// write is taken only when no item is in work.
module kiss64_random_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] range_limit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_wdata
);

   kiss64_pkg::kiss64_cmd_type cmd;

   kiss64_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   kiss64_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .seed        (csr_wdata),
      .range_limit (req_tdata),
      .value       (rsp_tdata)
   );

endmodule

// ===== hdl/kiss64_ctrl.sv =====
// Sequencing controller for the KISS random generator core.
// Depends on kiss64_pkg for the command struct; drives kiss64_dpath.
module kiss64_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output kiss64_pkg::kiss64_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LCG,
      ST_MIX,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register is free when empty or when its item leaves this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // A seed write wins over an item offered in the same cycle.
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.seed_load   = csr_valid && csr_ready;
      cmd.draw_start  = req_tvalid && req_tready;
      cmd.lcg_step    = (state_ff == ST_LCG);
      cmd.mix_step    = (state_ff == ST_MIX);
      cmd.result_load = (state_ff == ST_RESULT) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.draw_start) begin
               state_in = ST_LCG;
            end
         end
         ST_LCG: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/kiss64_dpath.sv =====
// Datapath of the KISS random generator: state words, split LCG multiply,
// sum and range scaling. Depends on kiss64_pkg; sequenced by kiss64_ctrl.
module kiss64_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kiss64_pkg::kiss64_cmd_type           cmd,
   input  logic [kiss64_pkg::WORD_W-1:0]        seed,
   input  logic [kiss64_pkg::RANGE_W-1:0]       range_limit,
   output logic [kiss64_pkg::WORD_W-1:0]        value
);

   localparam int unsigned W  = kiss64_pkg::WORD_W;
   localparam int unsigned HW = kiss64_pkg::HALF_W;
   localparam int unsigned RW = kiss64_pkg::RANGE_W;
   localparam int unsigned TW = W - kiss64_pkg::MWC_SHIFT;

   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  c_ff, c_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  z_ff, z_in;
   logic [RW-1:0] range_ff;
   logic [W-1:0]  pp_lo_ff, pp_lo_in;
   logic [HW-1:0] pp_hi_ff, pp_hi_in;
   logic [W-1:0]  xy_ff;
   logic [W-1:0]  sum_ff;
   logic [W-1:0]  value_ff, value_in;

   logic [W-1:0]  mwc_t;
   logic [TW-1:0] mwc_t_top;
   logic [W:0]    mwc_add;
   logic [W-1:0]  y1, y2;
   logic [W-1:0]  pp_hi_full;
   logic [HW-1:0] lcg_hi;
   logic [W-1:0]  scale_prod;

   // The shifted term only reaches the top bits, so t needs a narrow add there.
   always_comb begin
      mwc_t_top = c_ff[W-1 -: TW] + x_ff[TW-1:0];
      mwc_t     = {mwc_t_top, c_ff[kiss64_pkg::MWC_SHIFT-1:0]};
      mwc_add   = {1'b0, x_ff} + {1'b0, mwc_t};
      x_in      = mwc_add[W-1:0];
      c_in      = (x_ff >> kiss64_pkg::MWC_CSHIFT) + {{(W-1){1'b0}}, mwc_add[W]};
   end

   always_comb begin
      y1   = y_ff ^ (y_ff << kiss64_pkg::XS_A);
      y2   = y1 ^ (y1 >> kiss64_pkg::XS_B);
      y_in = y2 ^ (y2 << kiss64_pkg::XS_C);
   end

   // z * (2^32 + m) mod 2^64 = zl*m + ((zh*m + zl) << 32).
   always_comb begin
      pp_lo_in   = W'(z_ff[HW-1:0]) * W'(kiss64_pkg::LCG_MUL_LO);
      pp_hi_full = W'(z_ff[W-1:HW]) * W'(kiss64_pkg::LCG_MUL_LO);
      pp_hi_in   = pp_hi_full[HW-1:0];
      lcg_hi     = pp_hi_ff + z_ff[HW-1:0];
      z_in       = pp_lo_ff + {lcg_hi, {HW{1'b0}}} + kiss64_pkg::LCG_ADD;
   end

   always_comb begin
      scale_prod = W'(sum_ff[HW-1:0]) * W'(range_ff);
      if (range_ff == '0) begin
         value_in = sum_ff;
      end else begin
         value_in = {{(W-HW){1'b0}}, scale_prod[W-1:HW]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= kiss64_pkg::SEED_X_MASK;
         c_ff <= kiss64_pkg::SEED_C_MASK;
         y_ff <= kiss64_pkg::SEED_Y_MASK;
         z_ff <= kiss64_pkg::SEED_Z_MASK;
      end else if (cmd.seed_load) begin
         x_ff <= seed | kiss64_pkg::SEED_X_MASK;
         c_ff <= seed | kiss64_pkg::SEED_C_MASK;
         y_ff <= seed | kiss64_pkg::SEED_Y_MASK;
         z_ff <= seed | kiss64_pkg::SEED_Z_MASK;
      end else begin
         if (cmd.draw_start) begin
            x_ff <= x_in;
            c_ff <= c_in;
            y_ff <= y_in;
         end
         if (cmd.lcg_step) begin
            z_ff <= z_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         range_ff <= range_limit;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
      if (cmd.lcg_step) begin
         xy_ff <= x_ff + y_ff;
      end
      if (cmd.mix_step) begin
         sum_ff <= xy_ff + z_ff;
      end
      if (cmd.result_load) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
